// ===== src/dfcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfcd_pkg: shared types and constants of the command deframer
// Event codes, parse phase codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package dfcd_pkg;

	localparam logic [7:0] SYNC_FIRST_RST     = 8'hCC;
	localparam logic [7:0] SYNC_SECOND_RST    = 8'h44;
	localparam logic [7:0] NAME_SEPARATOR_RST = 8'h3A;

	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [1:0] CFG_SYNC_FIRST     = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND    = 2'd1;
	localparam logic [1:0] CFG_NAME_SEPARATOR = 2'd2;

	localparam logic [2:0] EV_DROP     = 3'd0;
	localparam logic [2:0] EV_START    = 3'd1;
	localparam logic [2:0] EV_HEADER   = 3'd2;
	localparam logic [2:0] EV_PAYLOAD  = 3'd3;
	localparam logic [2:0] EV_MOD_CHAR = 3'd4;
	localparam logic [2:0] EV_CMD_CHAR = 3'd5;
	localparam logic [2:0] EV_DATA     = 3'd6;
	localparam logic [2:0] EV_SEP      = 3'd7;

	localparam logic [1:0] REQ_SET      = 2'd0;
	localparam logic [1:0] REQ_GET      = 2'd1;
	localparam logic [1:0] REQ_RESPONSE = 2'd2;
	localparam logic [1:0] REQ_NONE     = 2'd3;

	localparam logic [3:0] PH_HUNT  = 4'd0;
	localparam logic [3:0] PH_SYNC2 = 4'd1;
	localparam logic [3:0] PH_MARK  = 4'd2;
	localparam logic [3:0] PH_TMOD  = 4'd3;
	localparam logic [3:0] PH_TCMD  = 4'd4;
	localparam logic [3:0] PH_TDATA = 4'd5;
	localparam logic [3:0] PH_BMOD  = 4'd6;
	localparam logic [3:0] PH_BCMD  = 4'd7;
	localparam logic [3:0] PH_BSTAT = 4'd8;
	localparam logic [3:0] PH_BSZH  = 4'd9;
	localparam logic [3:0] PH_BSZL  = 4'd10;
	localparam logic [3:0] PH_BCKH  = 4'd11;
	localparam logic [3:0] PH_BCKL  = 4'd12;
	localparam logic [3:0] PH_BPAY  = 4'd13;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  byte_value;
		logic [15:0] position;
		logic [7:0]  module_id;
		logic [7:0]  command_id;
		logic [7:0]  status_byte;
		logic [15:0] payload_size;
		logic [15:0] check_word;
		logic [1:0]  request_kind;
		logic        is_binary;
		logic        frame_end;
	} result_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage
`default_nettype wire

// ===== src/dfcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfcd_if: valid/ready channels of the command deframer
// Byte request channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface dfcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfcd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [7:0]  byte_value;
	logic [15:0] position;
	logic [7:0]  module_id;
	logic [7:0]  command_id;
	logic [7:0]  status_byte;
	logic [15:0] payload_size;
	logic [15:0] check_word;
	logic [1:0]  request_kind;
	logic        is_binary;
	logic        frame_end;

	modport source (output valid, output event_kind, output byte_value, output position,
		output module_id, output command_id, output status_byte, output payload_size,
		output check_word, output request_kind, output is_binary, output frame_end,
		input ready);
	modport sink (input valid, input event_kind, input byte_value, input position,
		input module_id, input command_id, input status_byte, input payload_size,
		input check_word, input request_kind, input is_binary, input frame_end,
		output ready);
endinterface
`default_nettype wire

// ===== src/dual_format_command_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_format_command_deframer: binary and text command frame parser
// Classifies each received byte of a binary or a text command frame.
//
// byte_stream carries one received byte per request. events returns one
// result per byte: its event kind, position in field, the binary header
// registers, the text request kind and a frame end flag.
// The parse state is updated in the cycle a byte is accepted; the result
// sits in an output register and is offered in the next cycle.
// Throughput is one byte per cycle while the receiver takes results, set by
// the single phase register update. A new byte is accepted while the
// output register is empty or is being emptied in the same cycle, so a
// stalled receiver holds the result and stops intake after one byte.
// cfg_wen/cfg_index/cfg_data write sync_first (0), sync_second (1) and
// name_separator (2); write them only while the block is idle.
// arst_n clears the parse state to hunting, the registers to their reset
// values and drops any pending result.
// ----------------------------------------------------------------------------
module dual_format_command_deframer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_wen,
	input  wire [1:0]        cfg_index,
	input  wire [7:0]        cfg_data,
	dfcd_byte_if.sink        byte_stream,
	dfcd_result_if.source    events
);
	import dfcd_pkg::*;

	logic [7:0]  sync_first_q, sync_second_q, name_sep_q;
	logic [3:0]  phase_q, phase_d;
	logic        binary_q, binary_d;
	logic        started_q, started_d;
	logic [7:0]  module_q, module_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  status_q, status_d;
	logic [15:0] size_q, size_d;
	logic [15:0] check_q, check_d;
	logic [15:0] left_q, left_d;
	logic [15:0] index_q, index_d;
	logic [1:0]  request_q, request_d;

	logic        out_valid_q;
	result_t     result_q, result_d;
	logic        accept;

	logic [7:0]  b;
	logic [2:0]  kind;
	logic [15:0] pos;
	logic        fend;
	logic        do_hunt, do_text;
	logic [7:0]  t_endc;
	logic [2:0]  t_kind;
	logic [3:0]  t_next;

	assign b = byte_stream.rx_byte;
	assign byte_stream.ready = !out_valid_q || events.ready;
	assign accept = byte_stream.valid && byte_stream.ready;

	always_comb begin
		phase_d   = phase_q;
		binary_d  = binary_q;
		started_d = started_q;
		module_d  = module_q;
		command_d = command_q;
		status_d  = status_q;
		size_d    = size_q;
		check_d   = check_q;
		left_d    = left_q;
		index_d   = index_q;
		request_d = request_q;
		kind      = EV_DROP;
		pos       = 16'd0;
		fend      = 1'b0;
		do_hunt   = 1'b0;
		do_text   = 1'b0;
		t_endc    = name_sep_q;
		t_kind    = EV_MOD_CHAR;
		t_next    = PH_TCMD;

		case (phase_q)
			PH_SYNC2: begin
				if (b == sync_second_q) begin
					binary_d  = 1'b1;
					request_d = REQ_NONE;
					module_d  = 8'd0;
					command_d = 8'd0;
					status_d  = 8'd0;
					size_d    = 16'd0;
					check_d   = 16'd0;
					left_d    = 16'd0;
					index_d   = 16'd0;
					phase_d   = PH_BMOD;
					kind      = EV_START;
					pos       = 16'd1;
				end else begin
					do_hunt = 1'b1;
				end
			end
			PH_MARK: begin
				if (b == CH_GT || b == CH_LT || b == CH_EQ) begin
					request_d = (b == CH_GT) ? REQ_SET :
						(b == CH_LT) ? REQ_GET : REQ_RESPONSE;
					kind    = EV_START;
					pos     = 16'd1;
					phase_d = PH_TMOD;
				end else begin
					phase_d = PH_TMOD;
					do_text = 1'b1;
				end
			end
			PH_TMOD: begin
				do_text = 1'b1;
			end
			PH_TCMD: begin
				do_text = 1'b1;
				t_kind  = EV_CMD_CHAR;
				t_next  = PH_TDATA;
			end
			PH_TDATA: begin
				do_text = 1'b1;
				t_endc  = CH_NEWLINE;
				t_kind  = EV_DATA;
				t_next  = PH_HUNT;
			end
			PH_BMOD: begin
				module_d = b;
				kind     = EV_HEADER;
				pos      = 16'd0;
				phase_d  = PH_BCMD;
			end
			PH_BCMD: begin
				command_d = b;
				kind      = EV_HEADER;
				pos       = 16'd1;
				phase_d   = PH_BSTAT;
			end
			PH_BSTAT: begin
				status_d = b;
				kind     = EV_HEADER;
				pos      = 16'd2;
				phase_d  = PH_BSZH;
			end
			PH_BSZH: begin
				size_d  = {b, 8'd0};
				kind    = EV_HEADER;
				pos     = 16'd3;
				phase_d = PH_BSZL;
			end
			PH_BSZL: begin
				size_d  = {size_q[15:8], b};
				left_d  = {size_q[15:8], b};
				kind    = EV_HEADER;
				pos     = 16'd4;
				phase_d = PH_BCKH;
			end
			PH_BCKH: begin
				check_d = {b, 8'd0};
				kind    = EV_HEADER;
				pos     = 16'd5;
				phase_d = PH_BCKL;
			end
			PH_BCKL: begin
				check_d = {check_q[15:8], b};
				kind    = EV_HEADER;
				pos     = 16'd6;
				index_d = 16'd0;
				if (left_q == 16'd0) begin
					phase_d = PH_HUNT;
					fend    = 1'b1;
				end else begin
					phase_d = PH_BPAY;
				end
			end
			PH_BPAY: begin
				kind    = EV_PAYLOAD;
				pos     = index_q;
				index_d = sat_inc(index_q);
				if (left_q != 16'd0) begin
					left_d = left_q - 16'd1;
				end
				if (left_q == 16'd0 || left_q == 16'd1) begin
					phase_d = PH_HUNT;
					fend    = 1'b1;
				end
			end
			default: begin
				do_hunt = 1'b1;
			end
		endcase

		if (do_hunt) begin
			pos = 16'd0;
			if (b == sync_first_q) begin
				phase_d = PH_SYNC2;
				kind    = EV_START;
			end else if (b == CH_AT) begin
				binary_d  = 1'b0;
				request_d = REQ_NONE;
				started_d = 1'b0;
				index_d   = 16'd0;
				phase_d   = PH_MARK;
				kind      = EV_START;
			end else begin
				phase_d = PH_HUNT;
				kind    = EV_DROP;
			end
		end

		if (do_text) begin
			pos = index_q;
			if (started_q && b == t_endc) begin
				kind      = EV_SEP;
				started_d = 1'b0;
				index_d   = 16'd0;
				phase_d   = t_next;
				fend      = (t_next == PH_HUNT);
			end else begin
				kind      = t_kind;
				index_d   = sat_inc(index_q);
				started_d = 1'b1;
			end
		end

		result_d.event_kind   = kind;
		result_d.byte_value   = b;
		result_d.position     = pos;
		result_d.module_id    = module_d;
		result_d.command_id   = command_d;
		result_d.status_byte  = status_d;
		result_d.payload_size = size_d;
		result_d.check_word   = check_d;
		result_d.request_kind = request_d;
		result_d.is_binary    = binary_d;
		result_d.frame_end    = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			name_sep_q    <= NAME_SEPARATOR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SYNC_FIRST:     sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND:    sync_second_q <= cfg_data;
				CFG_NAME_SEPARATOR: name_sep_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			binary_q  <= 1'b1;
			started_q <= 1'b0;
			module_q  <= 8'd0;
			command_q <= 8'd0;
			status_q  <= 8'd0;
			size_q    <= 16'd0;
			check_q   <= 16'd0;
			left_q    <= 16'd0;
			index_q   <= 16'd0;
			request_q <= REQ_NONE;
		end else if (accept) begin
			phase_q   <= phase_d;
			binary_q  <= binary_d;
			started_q <= started_d;
			module_q  <= module_d;
			command_q <= command_d;
			status_q  <= status_d;
			size_q    <= size_d;
			check_q   <= check_d;
			left_q    <= left_d;
			index_q   <= index_d;
			request_q <= request_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_stream.ready) begin
			out_valid_q <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign events.valid        = out_valid_q;
	assign events.event_kind   = result_q.event_kind;
	assign events.byte_value   = result_q.byte_value;
	assign events.position     = result_q.position;
	assign events.module_id    = result_q.module_id;
	assign events.command_id   = result_q.command_id;
	assign events.status_byte  = result_q.status_byte;
	assign events.payload_size = result_q.payload_size;
	assign events.check_word   = result_q.check_word;
	assign events.request_kind = result_q.request_kind;
	assign events.is_binary    = result_q.is_binary;
	assign events.frame_end    = result_q.frame_end;

endmodule
`default_nettype wire

// ===== test/dual_format_command_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_format_command_deframer_test: self-checking bench of the command deframer
// Sends binary and text command frames, broken frames and noise through the
// byte channel. Random idling on both channels and one long receiver stall
// are applied. A local parse model tracks the frame state and the sync and
// separator registers, and every returned event is checked field by field.
// ----------------------------------------------------------------------------
module dual_format_command_deframer_test;
	import dfcd_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_wen;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	dfcd_byte_if   byte_ch ();
	dfcd_result_if event_ch ();

	dual_format_command_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_stream(byte_ch),
		.events(event_ch)
	);

	logic [7:0]  sync_first_r;
	logic [7:0]  sync_second_r;
	logic [7:0]  separator_r;
	logic [3:0]  phase;
	logic        frame_bin;
	logic        fld_started;
	logic [7:0]  mod_r;
	logic [7:0]  cmd_r;
	logic [7:0]  stat_r;
	logic [15:0] size_r;
	logic [15:0] chk_r;
	logic [15:0] left_r;
	logic [15:0] idx_r;
	logic [1:0]  req_r;

	result_t expected_events[$];
	int      mismatch_count = 0;
	int      bytes_parsed = 0;
	bit      send_idle_on = 1'b0;
	bit      recv_idle_on = 1'b0;
	bit      holding = 1'b0;
	int      hold_cycles_req = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want, input logic [7:0] b);
		if (got !== want)
			report_mismatch($sformatf("byte %02h %s got %0h want %0h", b, name, got, want));
	endtask

	function automatic logic [15:0] bump_index(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void hunt_start(input logic [7:0] b, output logic [2:0] kind);
		if (b == sync_first_r) begin
			phase = PH_SYNC2;
			kind = EV_START;
		end else if (b == CH_AT) begin
			frame_bin = 1'b0;
			req_r = REQ_NONE;
			fld_started = 1'b0;
			idx_r = '0;
			phase = PH_MARK;
			kind = EV_START;
		end else begin
			phase = PH_HUNT;
			kind = EV_DROP;
		end
	endfunction

	function automatic void text_char(input logic [7:0] b, input logic [7:0] endc,
		input logic [2:0] char_kind, input logic [3:0] next_phase,
		output logic [2:0] kind, output logic [15:0] pos, output logic fend);
		fend = 1'b0;
		pos = idx_r;
		if (fld_started && b == endc) begin
			kind = EV_SEP;
			fld_started = 1'b0;
			idx_r = '0;
			phase = next_phase;
			fend = (next_phase == PH_HUNT);
		end else begin
			kind = char_kind;
			idx_r = bump_index(idx_r);
			fld_started = 1'b1;
		end
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b);
		result_t     r;
		logic [2:0]  kind;
		logic [15:0] pos;
		logic        fend;
		kind = EV_DROP;
		pos = '0;
		fend = 1'b0;
		case (phase)
			PH_SYNC2: begin
				if (b == sync_second_r) begin
					frame_bin = 1'b1;
					req_r = REQ_NONE;
					mod_r = '0;
					cmd_r = '0;
					stat_r = '0;
					size_r = '0;
					chk_r = '0;
					left_r = '0;
					idx_r = '0;
					phase = PH_BMOD;
					kind = EV_START;
					pos = 16'd1;
				end else begin
					hunt_start(b, kind);
				end
			end
			PH_MARK: begin
				if (b == CH_GT || b == CH_LT || b == CH_EQ) begin
					req_r = (b == CH_GT) ? REQ_SET : (b == CH_LT) ? REQ_GET : REQ_RESPONSE;
					kind = EV_START;
					pos = 16'd1;
					phase = PH_TMOD;
				end else begin
					phase = PH_TMOD;
					text_char(b, separator_r, EV_MOD_CHAR, PH_TCMD, kind, pos, fend);
				end
			end
			PH_TMOD: text_char(b, separator_r, EV_MOD_CHAR, PH_TCMD, kind, pos, fend);
			PH_TCMD: text_char(b, separator_r, EV_CMD_CHAR, PH_TDATA, kind, pos, fend);
			PH_TDATA: text_char(b, CH_NEWLINE, EV_DATA, PH_HUNT, kind, pos, fend);
			PH_BMOD: begin
				mod_r = b;
				kind = EV_HEADER;
				pos = 16'd0;
				phase = PH_BCMD;
			end
			PH_BCMD: begin
				cmd_r = b;
				kind = EV_HEADER;
				pos = 16'd1;
				phase = PH_BSTAT;
			end
			PH_BSTAT: begin
				stat_r = b;
				kind = EV_HEADER;
				pos = 16'd2;
				phase = PH_BSZH;
			end
			PH_BSZH: begin
				size_r = {b, 8'h00};
				kind = EV_HEADER;
				pos = 16'd3;
				phase = PH_BSZL;
			end
			PH_BSZL: begin
				size_r = {size_r[15:8], b};
				left_r = size_r;
				kind = EV_HEADER;
				pos = 16'd4;
				phase = PH_BCKH;
			end
			PH_BCKH: begin
				chk_r = {b, 8'h00};
				kind = EV_HEADER;
				pos = 16'd5;
				phase = PH_BCKL;
			end
			PH_BCKL: begin
				chk_r = {chk_r[15:8], b};
				kind = EV_HEADER;
				pos = 16'd6;
				idx_r = '0;
				if (left_r == 16'd0) begin
					phase = PH_HUNT;
					fend = 1'b1;
				end else begin
					phase = PH_BPAY;
				end
			end
			PH_BPAY: begin
				kind = EV_PAYLOAD;
				pos = idx_r;
				idx_r = bump_index(idx_r);
				if (left_r != 16'd0)
					left_r = left_r - 16'd1;
				if (left_r == 16'd0) begin
					phase = PH_HUNT;
					fend = 1'b1;
				end
			end
			default: hunt_start(b, kind);
		endcase
		r.event_kind = kind;
		r.byte_value = b;
		r.position = pos;
		r.module_id = mod_r;
		r.command_id = cmd_r;
		r.status_byte = stat_r;
		r.payload_size = size_r;
		r.check_word = chk_r;
		r.request_kind = req_r;
		r.is_binary = frame_bin;
		r.frame_end = fend;
		return r;
	endfunction

	task automatic reset_model();
		sync_first_r = SYNC_FIRST_RST;
		sync_second_r = SYNC_SECOND_RST;
		separator_r = NAME_SEPARATOR_RST;
		phase = PH_HUNT;
		frame_bin = 1'b1;
		fld_started = 1'b0;
		mod_r = '0;
		cmd_r = '0;
		stat_r = '0;
		size_r = '0;
		chk_r = '0;
		left_r = '0;
		idx_r = '0;
		req_r = REQ_NONE;
	endtask

	task automatic send_byte(input logic [7:0] b);
		result_t r;
		@(negedge clk);
		if (send_idle_on && $urandom_range(0, 5) == 0) begin
			byte_ch.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.rx_byte = b;
		do @(posedge clk); while (!byte_ch.ready);
		r = parse_byte(b);
		expected_events = {expected_events, r};
		if (r.event_kind != EV_DROP)
			bytes_parsed++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_binary(input logic [7:0] m, input logic [7:0] c, input logic [7:0] s,
		input logic [15:0] size, input logic [15:0] chk);
		send_byte(sync_first_r);
		send_byte(sync_second_r);
		send_byte(m);
		send_byte(c);
		send_byte(s);
		send_byte(size[15:8]);
		send_byte(size[7:0]);
		send_byte(chk[15:8]);
		send_byte(chk[7:0]);
		repeat (size) send_byte(8'($urandom));
	endtask

	task automatic send_text_field(input int len, input logic [7:0] endc, input bit no_mark);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			c = 8'($urandom);
			while ((i > 0 && c == endc)
				|| (i == 0 && no_mark && (c == CH_GT || c == CH_LT || c == CH_EQ)))
				c = 8'($urandom);
			send_byte(c);
		end
		send_byte(endc);
	endtask

	task automatic send_text_frame(input int mark, input int mod_len, input int cmd_len,
		input int data_len);
		send_byte(CH_AT);
		case (mark)
			0: send_byte(CH_GT);
			1: send_byte(CH_LT);
			2: send_byte(CH_EQ);
			default: ;
		endcase
		send_text_field(mod_len, separator_r, mark > 2);
		send_text_field(cmd_len, separator_r, 1'b0);
		send_text_field(data_len, CH_NEWLINE, 1'b0);
	endtask

	task automatic send_random_frame();
		int pick;
		int size;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			send_binary(8'($urandom), 8'($urandom), 8'($urandom), 16'(size),
				16'($urandom));
		end else if (pick < 85) begin
			send_text_frame($urandom_range(0, 3), $urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(1, 10));
		end else if (pick < 93) begin
			send_byte(sync_first_r);
			send_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end
	endtask

	task automatic drain_events();
		@(negedge clk);
		byte_ch.valid = 1'b0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			CFG_SYNC_FIRST: sync_first_r = data;
			CFG_SYNC_SECOND: sync_second_r = data;
			CFG_NAME_SEPARATOR: separator_r = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] sep);
		drain_events();
		write_reg(CFG_SYNC_FIRST, s1);
		write_reg(CFG_SYNC_SECOND, s2);
		write_reg(CFG_NAME_SEPARATOR, sep);
	endtask

	task automatic test_default_frames();
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		send_byte("?");
		send_binary(8'h00, 8'hFF, 8'h5A, 16'd2, 16'hA55A);
		send_string("@<a:b:c\n");
		send_string("@x:y:z\n");
	endtask

	task automatic test_special_cases();
		// wrong second sync restarts, then a zero size frame
		send_byte(SYNC_FIRST_RST);
		send_binary(8'h01, 8'h02, 8'h03, 16'd0, 16'h1234);
		// wrong second sync opens a text frame; first chars equal the terminators
		send_byte(SYNC_FIRST_RST);
		send_string("@=::::\n\n");
	endtask

	task automatic test_register_extremes();
		set_config(CH_AT, 8'h00, 8'hFF);
		send_binary(8'hFF, 8'h00, 8'hFF, 16'd1, 16'hFFFF);
		set_config(8'h00, 8'hFF, 8'h00);
		send_binary(8'h80, 8'h7F, 8'h01, 16'd1, 16'h0000);
		send_text_frame(3, 2, 2, 2);
		set_config(8'hFF, 8'hFF, CH_NEWLINE);
		send_byte(8'hFF);
		send_binary(8'hFF, 8'hFF, 8'hFF, 16'd1, 16'hFFFF);
		send_text_frame(0, 2, 2, 2);
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, NAME_SEPARATOR_RST);
	endtask

	task automatic test_backpressure();
		drain_events();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		hold_cycles_req = 300;
		send_binary(8'($urandom), 8'($urandom), 8'($urandom), 16'd20, 16'($urandom));
		send_text_frame(1, 4, 4, 8);
		drain_events();
	endtask

	task automatic test_long_fields();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		send_text_frame(3, 1, 1, 40);
		send_binary(8'h5A, 8'hA5, 8'hC3, 16'd40, 16'h3CC3);
		drain_events();
	endtask

	task automatic test_random_traffic();
		int goal;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		for (int p = 0; p < 4; p++) begin
			if (p == 0)
				set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, NAME_SEPARATOR_RST);
			else
				set_config(8'($urandom), 8'($urandom), 8'($urandom));
			goal = bytes_parsed + 100;
			while (bytes_parsed < goal)
				send_random_frame();
		end
	endtask

	task automatic test_full_rate();
		int goal;
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, NAME_SEPARATOR_RST);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		goal = bytes_parsed + 120;
		while (bytes_parsed < goal)
			send_random_frame();
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holding) begin
				event_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				event_ch.ready = 1'b0;
				stall_left--;
			end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				event_ch.ready = 1'b0;
			end else begin
				event_ch.ready = 1'b1;
			end
		end
	end

	initial begin : hold_timer
		forever begin
			@(posedge clk);
			if (hold_cycles_req > 0) begin
				holding = 1'b1;
				repeat (hold_cycles_req) @(posedge clk);
				holding = 1'b0;
				hold_cycles_req = 0;
			end
		end
	end

	always @(posedge clk) begin : event_check
		result_t want;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event for byte %02h", event_ch.byte_value));
			end else begin
				want = expected_events.pop_front();
				check_field("event_kind", 16'(event_ch.event_kind), 16'(want.event_kind),
					want.byte_value);
				check_field("byte_value", 16'(event_ch.byte_value), 16'(want.byte_value),
					want.byte_value);
				check_field("position", event_ch.position, want.position, want.byte_value);
				check_field("module_id", 16'(event_ch.module_id), 16'(want.module_id),
					want.byte_value);
				check_field("command_id", 16'(event_ch.command_id), 16'(want.command_id),
					want.byte_value);
				check_field("status_byte", 16'(event_ch.status_byte), 16'(want.status_byte),
					want.byte_value);
				check_field("payload_size", event_ch.payload_size, want.payload_size,
					want.byte_value);
				check_field("check_word", event_ch.check_word, want.check_word, want.byte_value);
				check_field("request_kind", 16'(event_ch.request_kind), 16'(want.request_kind),
					want.byte_value);
				check_field("is_binary", 16'(event_ch.is_binary), 16'(want.is_binary),
					want.byte_value);
				check_field("frame_end", 16'(event_ch.frame_end), 16'(want.frame_end),
					want.byte_value);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_SYNC_FIRST;
		cfg_data = 8'h00;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = 8'h00;
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_frames();
		test_special_cases();
		test_register_extremes();
		test_backpressure();
		test_long_fields();
		test_random_traffic();
		test_full_rate();
		drain_events();
		repeat (10) @(negedge clk);
		if (expected_events.size() != 0)
			report_mismatch("events still outstanding");
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dfcd_pkg.sv
src/dfcd_if.sv
src/dual_format_command_deframer.sv
test/dual_format_command_deframer_test.sv
